/* src/tgc_pkg.sv */
package tgc_pkg;

  // Fixed field widths.
  localparam int TIME_W        = 32;
  localparam int TAP_TIME_W    = 16;
  localparam int CFG_W         = 10;
  localparam int CFG_SQ_W      = 2 * CFG_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int GESTURE_W     = 3;
  localparam int OUT_TDATA_W   = 8;
  localparam int COORD_BITS_DEF = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_TIME      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MOVE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MIN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_BAND_END      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_BAND_START = 3'd5;

  // Register reset values. The two radius registers are kept squared.
  localparam logic [TAP_TIME_W-1:0] RST_TAP_MAX_TIME     = 16'd400;
  localparam logic [CFG_SQ_W-1:0]   RST_TAP_MOVE_SQ      = 20'd64;
  localparam logic [CFG_SQ_W-1:0]   RST_STROKE_SQ        = 20'd16;
  localparam logic [CFG_W-1:0]      RST_SWIPE_MIN        = 10'd40;
  localparam logic [CFG_W-1:0]      RST_TOP_BAND_END     = 10'd60;
  localparam logic [CFG_W-1:0]      RST_BOTTOM_BAND_START = 10'd180;

  typedef enum logic [GESTURE_W-1:0] {
    G_HIDE   = 3'd0,
    G_SHOW   = 3'd1,
    G_MENU   = 3'd2,
    G_PET    = 3'd3,
    G_STROKE = 3'd4
  } gesture_e;

endpackage

/* src/touch_gesture_classifier.sv */
// Touch gesture classifier.
//
// Input stream: one beat per touch sample on s_axis_*. Output stream: one beat
// per recognized gesture on m_axis_*; a sample that completes no gesture gives
// no beat. Gestures come out in sample order.
// The configuration channel (cfg_*) writes one threshold register per beat and
// is always ready; write it only while no sample is in flight.
// A sample accepted into the input register is classified from there, and the
// gesture it makes is loaded into the output register, which drives m_axis_*.
// Throughput: one sample per cycle, set by the single classification stage
// between the input register and the output register, while no gesture waits
// for a stalled output register.
// When the receiver stalls, the held gesture stays in the output register and
// the next sample can still be taken into the input register; samples that
// make no gesture keep flowing, and a sample that makes one waits in the input
// register, holding s_axis_tready low, until the output register frees up.
// Reset clears the touch tracking state and both stage valid flags, and loads
// the default thresholds.
module touch_gesture_classifier #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Fields from bit 0: now_time[32], touching, pos_x, pos_y, hit_pet, hit_bar,
  // zero fill to a whole byte.
  input  logic [((tgc_pkg::TIME_W + 3 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: gesture[3], zero fill.
  output logic [tgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tgc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tgc_pkg::*;

  localparam int CoordW = COORD_BITS;
  localparam int CmpW   = (CoordW > CFG_W) ? CoordW : CFG_W;
  localparam int SqW    = 2 * CoordW;
  localparam int SumW   = SqW + 1;
  localparam int DistW  = (SumW > CFG_SQ_W) ? SumW : CFG_SQ_W;
  localparam int XLo    = TIME_W + 1;
  localparam int YLo    = XLo + CoordW;
  localparam int PetBit = YLo + CoordW;
  localparam int BarBit = PetBit + 1;

  // Configuration registers. The radius thresholds are squared on write so the
  // classification path only compares.
  logic [TAP_TIME_W-1:0] tap_max_time_q;
  logic [CFG_SQ_W-1:0]   tap_move_sq_q, tap_move_sq_d;
  logic [CFG_SQ_W-1:0]   stroke_sq_q, stroke_sq_d;
  logic [CFG_W-1:0]      swipe_min_q, top_band_end_q, bottom_band_start_q;
  logic [CFG_W-1:0]      cfg_val;

  assign cfg_ready_o   = 1'b1;
  assign cfg_val       = cfg_data_i[CFG_W-1:0];
  assign tap_move_sq_d = CFG_SQ_W'(cfg_val) * CFG_SQ_W'(cfg_val);
  assign stroke_sq_d   = CFG_SQ_W'(cfg_val) * CFG_SQ_W'(cfg_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_max_time_q      <= RST_TAP_MAX_TIME;
      tap_move_sq_q       <= RST_TAP_MOVE_SQ;
      stroke_sq_q         <= RST_STROKE_SQ;
      swipe_min_q         <= RST_SWIPE_MIN;
      top_band_end_q      <= RST_TOP_BAND_END;
      bottom_band_start_q <= RST_BOTTOM_BAND_START;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TAP_MAX_TIME:      tap_max_time_q      <= cfg_data_i;
        CFG_TAP_MAX_MOVE:      tap_move_sq_q       <= tap_move_sq_d;
        CFG_STROKE_STEP:       stroke_sq_q         <= stroke_sq_d;
        CFG_SWIPE_MIN:         swipe_min_q         <= cfg_val;
        CFG_TOP_BAND_END:      top_band_end_q      <= cfg_val;
        CFG_BOTTOM_BAND_START: bottom_band_start_q <= cfg_val;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  logic              in_valid_q;
  logic [TIME_W-1:0] in_time_q;
  logic              in_touch_q;
  logic [CoordW-1:0] in_x_q, in_y_q;
  logic              in_pet_q, in_bar_q;
  logic              proceed;

  assign s_axis_tready = !in_valid_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_time_q  <= s_axis_tdata[TIME_W-1:0];
      in_touch_q <= s_axis_tdata[TIME_W];
      in_x_q     <= s_axis_tdata[XLo +: CoordW];
      in_y_q     <= s_axis_tdata[YLo +: CoordW];
      in_pet_q   <= s_axis_tdata[PetBit];
      in_bar_q   <= s_axis_tdata[BarBit];
    end
  end

  // Touch tracking state.
  logic              was_down_q;
  logic [TIME_W-1:0] start_time_q;
  logic [CoordW-1:0] start_x_q, start_y_q, anchor_x_q, anchor_y_q;
  logic              anchor_pet_q, anchor_bar_q;

  // Distance datapath, shared between the move test (sample against anchor)
  // and the release test (anchor against start).
  logic [CoordW-1:0]   op_ax, op_bx, op_ay, op_by;
  logic signed [CoordW:0] diff_x, diff_y;
  logic [CoordW-1:0]   abs_x, abs_y;
  logic [SqW-1:0]      sq_x, sq_y;
  logic [SumW-1:0]     dist_sq;
  logic [TIME_W-1:0]   elapsed;

  always_comb begin
    if (in_touch_q) begin
      op_ax = in_x_q;
      op_bx = anchor_x_q;
      op_ay = in_y_q;
      op_by = anchor_y_q;
    end else begin
      op_ax = anchor_x_q;
      op_bx = start_x_q;
      op_ay = anchor_y_q;
      op_by = start_y_q;
    end
  end

  assign diff_x  = $signed({1'b0, op_ax}) - $signed({1'b0, op_bx});
  assign diff_y  = $signed({1'b0, op_ay}) - $signed({1'b0, op_by});
  assign abs_x   = diff_x[CoordW] ? CoordW'(-diff_x) : diff_x[CoordW-1:0];
  assign abs_y   = diff_y[CoordW] ? CoordW'(-diff_y) : diff_y[CoordW-1:0];
  assign sq_x    = SqW'(abs_x) * SqW'(abs_x);
  assign sq_y    = SqW'(abs_y) * SqW'(abs_y);
  assign dist_sq = SumW'(sq_x) + SumW'(sq_y);
  assign elapsed = in_time_q - start_time_q;

  // Classification.
  logic     res_valid;
  gesture_e res_gesture;
  logic     take_start;
  logic     take_anchor;
  logic     swipe_ok, in_top, in_bottom, tap_ok;

  assign swipe_ok  = (CmpW'(abs_y) >= CmpW'(swipe_min_q)) && (abs_y > abs_x);
  assign in_top    = CmpW'(start_y_q) < CmpW'(top_band_end_q);
  assign in_bottom = CmpW'(start_y_q) >= CmpW'(bottom_band_start_q);
  assign tap_ok    = (elapsed <= TIME_W'(tap_max_time_q)) &&
                     (DistW'(dist_sq) <= DistW'(tap_move_sq_q));

  always_comb begin
    res_valid   = 1'b0;
    res_gesture = G_STROKE;
    take_start  = 1'b0;
    take_anchor = 1'b0;
    if (in_touch_q && !was_down_q) begin
      // Touch down: start and anchor both take the sample.
      take_start  = 1'b1;
      take_anchor = 1'b1;
    end else if (!in_touch_q && was_down_q) begin
      // Release: a band swipe wins over a tap. The top band is tested first.
      if (swipe_ok && in_top) begin
        res_valid   = 1'b1;
        res_gesture = diff_y[CoordW] ? G_HIDE : G_SHOW;
      end else if (swipe_ok && in_bottom) begin
        res_valid   = 1'b1;
        res_gesture = diff_y[CoordW] ? G_SHOW : G_HIDE;
      end else if (tap_ok && anchor_bar_q) begin
        res_valid   = 1'b1;
        res_gesture = G_MENU;
      end else if (tap_ok && anchor_pet_q) begin
        res_valid   = 1'b1;
        res_gesture = G_PET;
      end
    end else if (in_touch_q && was_down_q) begin
      // Held touch: a long enough step onto the pet is a stroke.
      if ((DistW'(dist_sq) >= DistW'(stroke_sq_q)) && in_pet_q) begin
        res_valid   = 1'b1;
        res_gesture = G_STROKE;
        take_anchor = 1'b1;
      end
    end
  end

  // A sample without a gesture never waits for the output register.
  assign proceed = in_valid_q && (!res_valid || !m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q   <= 1'b0;
      start_time_q <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      anchor_x_q   <= '0;
      anchor_y_q   <= '0;
      anchor_pet_q <= 1'b0;
      anchor_bar_q <= 1'b0;
    end else if (proceed) begin
      was_down_q <= in_touch_q;
      if (take_start) begin
        start_time_q <= in_time_q;
        start_x_q    <= in_x_q;
        start_y_q    <= in_y_q;
      end
      if (take_anchor) begin
        anchor_x_q   <= in_x_q;
        anchor_y_q   <= in_y_q;
        anchor_pet_q <= in_pet_q;
        anchor_bar_q <= in_bar_q;
      end
    end
  end

  // Output register.
  logic     out_valid_q, out_valid_d;
  gesture_e gesture_q;

  always_comb begin
    out_valid_d = m_axis_tvalid;
    if (proceed && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && res_valid) begin
      gesture_q <= res_gesture;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - GESTURE_W){1'b0}}, gesture_q};

  // Checks.
  a_touch_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed |=> (was_down_q == $past(in_touch_q)))
    else $error("touch state did not follow the classified sample");

  a_stroke_moves_anchor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && res_valid && (res_gesture == G_STROKE)) |=>
      ((anchor_x_q == $past(in_x_q)) && (anchor_y_q == $past(in_y_q))))
    else $error("stroke did not move the anchor");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_touch_q && !was_down_q) |-> !res_valid)
    else $error("gesture raised with no touch");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && res_valid && m_axis_tvalid))
    else $error("input stalled without a pending gesture");

endmodule
